>>> rtl/tsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and the displacement helper for the turtle segment generator
// depends on nothing; used by the channel interfaces and the core

package tsg_pkg;

  localparam int SINE_TABLE_ENTRIES_DEFAULT = 256;

  // pi/2 in Q30, truncated
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [7:0] SYM_FORWARD = 8'h46;
  localparam logic [7:0] SYM_MINUS   = 8'h2D;
  localparam logic [7:0] SYM_PLUS    = 8'h2B;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_TURN_ANGLE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_X     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y     = 2'd3;

  localparam logic [15:0]        TURN_ANGLE_RESET  = 16'd10917;
  localparam logic [15:0]        STEP_LENGTH_RESET = 16'd282;
  localparam logic signed [31:0] START_X_RESET     = 32'sd26214400;
  localparam logic signed [31:0] START_Y_RESET     = 32'sd18022400;

  // quarter wave entries are Q1.16 with the top entry equal to 1.0
  localparam int TRIG_W = 17;

  typedef logic [TRIG_W-1:0]  trig_t;
  typedef logic signed [31:0] coord_t;
  typedef logic [15:0]        phase_t;

  // step_length times |trig|, rounded half up to Q16.16, then signed
  function automatic coord_t displacement(input logic [15:0] step, input trig_t trig,
                                          input logic negative);
    logic [32:0] prod;
    logic [24:0] mag;
    prod = 33'(step) * 33'(trig) + 33'd128;
    mag  = prod[32:8];
    return negative ? -signed'(32'(mag)) : signed'(32'(mag));
  endfunction

endpackage

`default_nettype wire

>>> rtl/tsg_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channel interfaces: symbol input, segment output, register writes
// depends on tsg_pkg

interface tsg_symbol_if import tsg_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       begin_string;

  modport source (output valid, output symbol, output begin_string, input ready);
  modport sink (input valid, input symbol, input begin_string, output ready);
endinterface

interface tsg_segment_if import tsg_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t from_x;
  coord_t from_y;
  coord_t to_x;
  coord_t to_y;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  input ready);
  modport sink (input valid, input from_x, input from_y, input to_x, input to_y,
                output ready);
endinterface

interface tsg_cfg_if import tsg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/turtle_segment_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// turtle segment generator: L-system symbols in, line segments out
// depends on tsg_pkg and the channel interfaces in tsg_channels.sv
//
// usage:
//   symbols  - one symbol per transaction; 'F' moves the pen, '-' and '+' turn it,
//              anything else is dropped. begin_string puts the pen back at
//              (start_x, start_y) with heading zero before the symbol is applied.
//   segments - one transaction per 'F': old pen point and new pen point, Q16.16.
//   cfg      - register writes (turn_angle, step_length, start_x, start_y), always
//              ready; write only while no symbol is in flight.
// timing:
//   a symbol lands in the input register and is applied from there to the pen state,
//   an 'F' also loading the segment register. one symbol per cycle is sustained
//   while segments does not stall; the limit is the single path from heading through
//   the sine table lookup, the step multiply and the coordinate add, which must
//   finish before the following symbol uses the pen.
// reset (rst, synchronous) restores register defaults, puts the pen at the reset
// start point and empties both registers. when segments stalls, the pending segment
// holds and turn or dropped symbols keep flowing; the next 'F' waits in the input
// register and symbols.ready stays low until the pending segment is taken.

module turtle_segment_generator_core import tsg_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEFAULT
) (
  input  wire          clk,
  input  wire          rst,
  tsg_symbol_if.sink   symbols,
  tsg_segment_if.source segments,
  tsg_cfg_if.sink      cfg
);

  localparam int IdxW  = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int ProdW = 15 + IdxW;
  localparam logic [15:0] QuarterTurn = 16'h4000;
  localparam logic [14:0] QuarterSpan = 15'h4000;

  // quarter wave table, built at elaboration
  trig_t sine_rom [0:SINE_TABLE_ENTRIES];

  // taylor series of sin(x), x in Q30, rounded to Q1.16
  for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [63:0] Angle   = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_ENTRIES);
    localparam logic [63:0] AngleSq = (Angle * Angle) >> 30;
    localparam logic [63:0] Term1   = ((Angle * AngleSq) >> 30) / 64'd6;
    localparam logic [63:0] Term2   = ((Term1 * AngleSq) >> 30) / 64'd20;
    localparam logic [63:0] Term3   = ((Term2 * AngleSq) >> 30) / 64'd42;
    localparam logic [63:0] Term4   = ((Term3 * AngleSq) >> 30) / 64'd72;
    localparam logic [63:0] Term5   = ((Term4 * AngleSq) >> 30) / 64'd110;
    localparam logic [63:0] Term6   = ((Term5 * AngleSq) >> 30) / 64'd156;
    localparam logic [63:0] Term7   = ((Term6 * AngleSq) >> 30) / 64'd210;
    localparam logic [63:0] Term8   = ((Term7 * AngleSq) >> 30) / 64'd272;
    localparam logic [63:0] Term9   = ((Term8 * AngleSq) >> 30) / 64'd342;
    localparam logic [63:0] Term10  = ((Term9 * AngleSq) >> 30) / 64'd420;
    localparam logic [63:0] Term11  = ((Term10 * AngleSq) >> 30) / 64'd506;
    localparam logic [63:0] Term12  = ((Term11 * AngleSq) >> 30) / 64'd600;
    localparam logic signed [63:0] Sum = signed'(Angle)
        - signed'(Term1) + signed'(Term2) - signed'(Term3) + signed'(Term4)
        - signed'(Term5) + signed'(Term6) - signed'(Term7) + signed'(Term8)
        - signed'(Term9) + signed'(Term10) - signed'(Term11) + signed'(Term12);
    localparam logic [63:0] Rounded =
        (Sum < 0) ? 64'd0 : ((unsigned'(Sum) + 64'd8192) >> 14);
    localparam logic [63:0] Clamped = (Rounded > 64'd65536) ? 64'd65536 : Rounded;
    assign sine_rom[k] = Clamped[TRIG_W-1:0];
  end

  function automatic logic [IdxW-1:0] rom_index(input phase_t h);
    logic [14:0]      p;
    logic [ProdW-1:0] prod;
    p = {1'b0, h[13:0]};
    if (h[14]) begin
      p = QuarterSpan - p;
    end
    prod = ProdW'(p) * ProdW'(SINE_TABLE_ENTRIES);
    return IdxW'(prod >> 14);
  endfunction

  // configuration registers
  logic [15:0] turn_angle;
  logic [15:0] step_length;
  coord_t      start_x;
  coord_t      start_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_angle  <= TURN_ANGLE_RESET;
      step_length <= STEP_LENGTH_RESET;
      start_x     <= START_X_RESET;
      start_y     <= START_Y_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TURN_ANGLE:  turn_angle  <= cfg.data[15:0];
        REG_STEP_LENGTH: step_length <= cfg.data[15:0];
        REG_START_X:     start_x     <= signed'(cfg.data);
        REG_START_Y:     start_y     <= signed'(cfg.data);
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid;
  logic [7:0] sym;
  logic       restart;

  // pen state
  coord_t pen_x;
  coord_t pen_y;
  phase_t heading;

  // output register
  logic   out_valid;
  coord_t from_x;
  coord_t from_y;
  coord_t to_x;
  coord_t to_y;

  logic   is_forward;
  logic   advance;
  logic   out_free;
  coord_t base_x;
  coord_t base_y;
  phase_t base_heading;
  phase_t cos_phase;
  coord_t step_x;
  coord_t step_y;
  coord_t next_x;
  coord_t next_y;
  phase_t heading_next;

  assign is_forward = (sym == SYM_FORWARD);
  assign out_free   = !out_valid || segments.ready;
  // a symbol with no segment never waits on the output side
  assign advance    = in_valid && (out_free || !is_forward);

  assign symbols.ready = !in_valid || advance;

  always_comb begin
    base_x       = restart ? start_x : pen_x;
    base_y       = restart ? start_y : pen_y;
    base_heading = restart ? '0 : heading;
    cos_phase    = base_heading + QuarterTurn;
    step_x = displacement(step_length, sine_rom[rom_index(cos_phase)], cos_phase[15]);
    step_y = displacement(step_length, sine_rom[rom_index(base_heading)], base_heading[15]);
    next_x = base_x + step_x;
    next_y = base_y + step_y;
    unique case (sym)
      SYM_MINUS: heading_next = base_heading - turn_angle;
      SYM_PLUS:  heading_next = base_heading + turn_angle;
      default:   heading_next = base_heading;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (symbols.ready) begin
      in_valid <= symbols.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (symbols.ready && symbols.valid) begin
      sym     <= symbols.symbol;
      restart <= symbols.begin_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x   <= START_X_RESET;
      pen_y   <= START_Y_RESET;
      heading <= '0;
    end else if (advance) begin
      heading <= heading_next;
      if (is_forward) begin
        pen_x <= next_x;
        pen_y <= next_y;
      end else begin
        pen_x <= base_x;
        pen_y <= base_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && is_forward;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_forward) begin
      from_x <= base_x;
      from_y <= base_y;
      to_x   <= next_x;
      to_y   <= next_y;
    end
  end

  assign segments.valid  = out_valid;
  assign segments.from_x = from_x;
  assign segments.from_y = from_y;
  assign segments.to_x   = to_x;
  assign segments.to_y   = to_y;

endmodule

`default_nettype wire

>>> dv/turtle_segment_generator_core_test.sv
`timescale 1ns / 1ps
// testbench for turtle_segment_generator_core: symbol strings in, segments checked
// against a local turtle predictor; depends on tsg_pkg and the channels in tsg_channels.sv

module turtle_segment_generator_core_test;
  import tsg_pkg::*;

  localparam int SINE_ENTRIES = SINE_TABLE_ENTRIES_DEFAULT;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int CHUNK_ITEMS  = 50;

  typedef struct packed {
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
  } segment_t;

  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tsg_symbol_if  symbols_ch ();
  tsg_segment_if segments_ch ();
  tsg_cfg_if     cfg_ch ();

  turtle_segment_generator_core dut (
    .clk      (clk),
    .rst      (rst),
    .symbols  (symbols_ch),
    .segments (segments_ch),
    .cfg      (cfg_ch)
  );

  // turtle state and register copies
  logic [15:0] turn_angle_q;
  logic [15:0] step_length_q;
  coord_t      start_x_q;
  coord_t      start_y_q;
  coord_t      pen_x_q;
  coord_t      pen_y_q;
  phase_t      heading_q;

  logic [16:0] quarter_sine [0:SINE_ENTRIES];
  segment_t    pending_segments[$];
  segment_t    oldest_segment;

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;

  task automatic build_quarter_sine();
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic signed [63:0] acc;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - signed'(term);
        end else begin
          acc = acc + signed'(term);
        end
      end
      if (acc < 0) begin
        acc = 64'sd0;
      end
      mag = (unsigned'(acc) + 64'd8192) >> 14;
      if (mag > 64'd65536) begin
        mag = 64'd65536;
      end
      quarter_sine[k] = mag[16:0];
    end
  endtask

  // step_length times sin(h), signed Q16.16
  function automatic coord_t axis_move(input phase_t h);
    logic [1:0]  quad;
    logic [14:0] p;
    logic [31:0] idx;
    logic [63:0] mag;
    quad = h[15:14];
    p    = {1'b0, h[13:0]};
    if (quad[0]) begin
      p = 15'd16384 - p;
    end
    idx = (32'(p) * SINE_ENTRIES) >> 14;
    if (idx > SINE_ENTRIES) begin
      idx = SINE_ENTRIES;
    end
    mag = (64'(step_length_q) * 64'(quarter_sine[idx]) + 64'd128) >> 8;
    return quad[1] ? coord_t'(32'd0 - mag[31:0]) : coord_t'(mag[31:0]);
  endfunction

  task automatic advance_turtle(input logic [7:0] sym, input logic beg);
    segment_t seg;
    phase_t   cos_phase;
    if (beg) begin
      pen_x_q   = start_x_q;
      pen_y_q   = start_y_q;
      heading_q = '0;
    end
    case (sym)
      SYM_MINUS: begin
        heading_q = heading_q - turn_angle_q;
      end
      SYM_PLUS: begin
        heading_q = heading_q + turn_angle_q;
      end
      SYM_FORWARD: begin
        cos_phase   = heading_q + 16'h4000;
        seg.from_x  = pen_x_q;
        seg.from_y  = pen_y_q;
        seg.to_x    = pen_x_q + axis_move(cos_phase);
        seg.to_y    = pen_y_q + axis_move(heading_q);
        pen_x_q     = seg.to_x;
        pen_y_q     = seg.to_y;
        pending_segments.push_back(seg);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_symbol(input logic [7:0] sym, input logic beg);
    while ($urandom_range(99) < send_idle_pct) begin
      symbols_ch.valid <= 1'b0;
      @(posedge clk);
    end
    symbols_ch.valid        <= 1'b1;
    symbols_ch.symbol       <= sym;
    symbols_ch.begin_string <= beg;
    @(posedge clk);
    while (!symbols_ch.ready) begin
      @(posedge clk);
    end
    advance_turtle(sym, beg);
  endtask

  // the last symbol may cause no segment, so keep clocking for DRAIN_CYCLES once the queue is empty
  task automatic wait_pipeline_empty();
    symbols_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_segments.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_TURN_ANGLE:  turn_angle_q  = value[15:0];
      REG_STEP_LENGTH: step_length_q = value[15:0];
      REG_START_X:     start_x_q     = value;
      REG_START_Y:     start_y_q     = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic [15:0] turn, input logic [15:0] step,
                            input logic [31:0] sx, input logic [31:0] sy);
    wait_pipeline_empty();
    write_reg(REG_TURN_ANGLE, 32'(turn));
    write_reg(REG_STEP_LENGTH, 32'(step));
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 45) return SYM_FORWARD;
    if (r < 65) return SYM_PLUS;
    if (r < 85) return SYM_MINUS;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] random_turn();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'h4000;
      3: return TURN_ANGLE_RESET;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_step();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_start();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // pen comes out of reset at the default start point, no register written yet
  task automatic test_reset_defaults();
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    // begin on an ignored symbol still puts the pen back
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hFF, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(8'h66, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
  endtask

  task automatic test_register_extremes();
    // longest step from the coordinate extremes: position wraps
    set_config(16'h4000, 16'hFFFF, 32'h7FFF_0000, 32'h8000_0000);
    send_symbol(SYM_FORWARD, 1'b1);
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_PLUS, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    // heading wraps both ways, zero length segments
    set_config(16'hFFFF, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_symbol(SYM_PLUS, 1'b1);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_MINUS, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
  endtask

  // strings mostly open with begin_string; some continue from the old pen
  task automatic test_random_strings(input int count);
    int sent;
    int len;
    logic beg;
    sent = 0;
    while (sent < count) begin
      if (sent % CHUNK_ITEMS == 0) begin
        set_config(random_turn(), random_step(), random_start(), random_start());
      end
      len = $urandom_range(3, 40);
      for (int i = 0; i < len && sent < count; i++) begin
        if (i == 0) begin
          beg = ($urandom_range(99) < 90);
        end else begin
          beg = ($urandom_range(99) < 2);
        end
        send_symbol(random_symbol(), beg);
        sent++;
        if (sent % CHUNK_ITEMS == 0) begin
          break;
        end
      end
    end
  endtask

  // segments held off for a long stretch while symbols keep coming
  task automatic test_receiver_stall();
    set_config(random_turn(), random_step(), random_start(), random_start());
    stall_request = 300;
    send_symbol(SYM_FORWARD, 1'b1);
    for (int i = 0; i < 39; i++) begin
      send_symbol(($urandom_range(3) == 0) ? SYM_PLUS : SYM_FORWARD, 1'b0);
    end
  endtask

  function automatic void check_field(input string name, input coord_t want,
                                      input coord_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && segments_ch.valid && segments_ch.ready) begin
      if (pending_segments.size() == 0) begin
        $display("%0t: segment with none expected, expected nothing actual (%0d,%0d)-(%0d,%0d)",
                 $time, segments_ch.from_x, segments_ch.from_y,
                 segments_ch.to_x, segments_ch.to_y);
        mismatches++;
      end else begin
        oldest_segment = pending_segments.pop_front();
        check_field("from_x", oldest_segment.from_x, segments_ch.from_x);
        check_field("from_y", oldest_segment.from_y, segments_ch.from_y);
        check_field("to_x", oldest_segment.to_x, segments_ch.to_x);
        check_field("to_y", oldest_segment.to_y, segments_ch.to_y);
      end
    end
  end

  initial begin : segment_receiver
    int stall_left;
    stall_left = 0;
    segments_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        segments_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        segments_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((symbols_ch.valid && symbols_ch.ready) ||
          (segments_ch.valid && segments_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst                     <= 1'b1;
    symbols_ch.valid        <= 1'b0;
    symbols_ch.symbol       <= '0;
    symbols_ch.begin_string <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= '0;
    cfg_ch.data             <= '0;
    build_quarter_sine();
    turn_angle_q  = TURN_ANGLE_RESET;
    step_length_q = STEP_LENGTH_RESET;
    start_x_q     = START_X_RESET;
    start_y_q     = START_Y_RESET;
    pen_x_q       = START_X_RESET;
    pen_y_q       = START_Y_RESET;
    heading_q     = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 57;
    test_reset_defaults();
    test_register_extremes();
    test_random_strings(200);

    send_idle_pct = 57;
    recv_idle_pct = 13;
    test_random_strings(200);
    test_receiver_stall();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_strings(200);

    symbols_ch.valid <= 1'b0;
    while (pending_segments.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tsg_pkg.sv
rtl/tsg_channels.sv
rtl/turtle_segment_generator_core.sv
dv/turtle_segment_generator_core_test.sv
